// ===== rtl/aosc_pkg.sv =====
// Shared widths, register codes, reset values and types for the octagon clamp block.
// No dependencies; the RTL files refer to it by scoped names, the bench files import it.
package aosc_pkg;

    // Field and word widths
    localparam int DATA_W    = 9;
    localparam int TDATA_W   = 56;
    localparam int NUM_FIELD = 6;
    localparam int CFG_W     = 8;
    localparam int ADDR_W    = 3;

    // Stick datapath widths
    localparam int MAG_W     = 9;
    localparam int PA_W      = 17;
    localparam int PB_W      = 19;
    localparam int WM_W      = 16;
    localparam int SUM_W     = 20;
    localparam int DEN_W     = 17;
    localparam int NUM_W     = WM_W + MAG_W;
    localparam int QUO_W     = 9;

    // Pipeline shape: three front stages, one divider stage per quotient bit, one output stage
    localparam int FRONT_STG = 3;
    localparam int DIV_STEPS = QUO_W;
    localparam int NUM_STG   = FRONT_STG + DIV_STEPS + 1;

    // Register reset values
    localparam logic [CFG_W-1:0] TRIG_DEAD_RST   = 8'd30;
    localparam logic [CFG_W-1:0] TRIG_LIMIT_RST  = 8'd180;
    localparam logic [CFG_W-1:0] LEFT_DEAD_RST   = 8'd15;
    localparam logic [CFG_W-1:0] LEFT_LIMIT_RST  = 8'd72;
    localparam logic [CFG_W-1:0] LEFT_DIAG_RST   = 8'd40;
    localparam logic [CFG_W-1:0] RIGHT_DEAD_RST  = 8'd15;
    localparam logic [CFG_W-1:0] RIGHT_LIMIT_RST = 8'd59;
    localparam logic [CFG_W-1:0] RIGHT_DIAG_RST  = 8'd31;

    // Register index codes
    typedef enum logic [ADDR_W-1:0] {
        REG_TRIG_DEAD   = 3'd0,
        REG_TRIG_LIMIT  = 3'd1,
        REG_LEFT_DEAD   = 3'd2,
        REG_LEFT_LIMIT  = 3'd3,
        REG_LEFT_DIAG   = 3'd4,
        REG_RIGHT_DEAD  = 3'd5,
        REG_RIGHT_LIMIT = 3'd6,
        REG_RIGHT_DIAG  = 3'd7
    } aosc_reg_t;

    // Per-stick region settings
    typedef struct packed {
        logic [CFG_W-1:0] dead;
        logic [CFG_W-1:0] limit;
        logic [CFG_W-1:0] diag;
    } aosc_stick_cfg_t;

    // Side information carried alongside the divider
    typedef struct packed {
        logic             neg_x;
        logic             neg_y;
        logic             scale;
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
    } aosc_side_t;

    typedef logic [NUM_STG-1:0] aosc_en_t;

endpackage

// ===== rtl/aosc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for the stick rescale.
// Depends on aosc_pkg for widths and the number of steps.
module aosc_div (
    input  logic                                aclk,
    input  logic [aosc_pkg::DIV_STEPS-1:0]      en,
    input  logic [aosc_pkg::NUM_W-1:0]          num,
    input  logic [aosc_pkg::DEN_W-1:0]          den,
    output logic [aosc_pkg::QUO_W-1:0]          quo
);

    localparam int CMP_W = aosc_pkg::NUM_W + 1;

    logic [aosc_pkg::NUM_W-1:0] rem_reg [aosc_pkg::DIV_STEPS-1];
    logic [aosc_pkg::DEN_W-1:0] den_reg [aosc_pkg::DIV_STEPS-1];
    logic [aosc_pkg::QUO_W-1:0] quo_reg [aosc_pkg::DIV_STEPS];

    for (genvar i = 0; i < aosc_pkg::DIV_STEPS; i++) begin : g_step
        localparam int SHIFT = aosc_pkg::DIV_STEPS - 1 - i;

        logic [aosc_pkg::NUM_W-1:0] rem_in;
        logic [aosc_pkg::DEN_W-1:0] den_in;
        logic [aosc_pkg::QUO_W-1:0] quo_in;
        logic [CMP_W-1:0]           den_sh;
        logic [CMP_W-1:0]           trial;
        logic [aosc_pkg::NUM_W-1:0] rem_next;
        logic [aosc_pkg::QUO_W-1:0] quo_next;

        if (i == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        // Subtract the shifted divisor; keep the remainder when it goes negative
        always_comb begin
            den_sh = CMP_W'(den_in) << SHIFT;
            trial  = {1'b0, rem_in} - den_sh;
            if (!trial[CMP_W-1]) begin
                rem_next = trial[aosc_pkg::NUM_W-1:0];
                quo_next = quo_in | (aosc_pkg::QUO_W'(1) << SHIFT);
            end else begin
                rem_next = rem_in;
                quo_next = quo_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[i]) begin
                quo_reg[i] <= quo_next;
            end
        end

        // Last step needs no remainder or divisor downstream
        if (i < aosc_pkg::DIV_STEPS - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (en[i]) begin
                    rem_reg[i] <= rem_next;
                    den_reg[i] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[aosc_pkg::DIV_STEPS-1];

endmodule

// ===== rtl/aosc_stick.sv =====
// One stick's path: sign split, dead zone, octagon test, pipelined rescale, sign restore.
// Depends on aosc_pkg and aosc_div; stage enables come from the top level.
module aosc_stick (
    input  logic                              aclk,
    input  aosc_pkg::aosc_en_t                en,
    input  aosc_pkg::aosc_stick_cfg_t         cfg,
    input  logic [aosc_pkg::DATA_W-1:0]       pos_x,
    input  logic [aosc_pkg::DATA_W-1:0]       pos_y,
    output logic [aosc_pkg::DATA_W-1:0]       out_x,
    output logic [aosc_pkg::DATA_W-1:0]       out_y
);

    localparam int MAG_W = aosc_pkg::MAG_W;
    localparam int LAST  = aosc_pkg::NUM_STG - 1;

    // Stage 0: sign and post-dead magnitude
    logic             neg_x_next, neg_y_next;
    logic [MAG_W-1:0] abs_x, abs_y;
    logic [MAG_W-1:0] mag_x_next, mag_y_next;
    logic             s0_neg_x_reg, s0_neg_y_reg;
    logic [MAG_W-1:0] s0_mag_x_reg, s0_mag_y_reg;

    always_comb begin
        neg_x_next = pos_x[MAG_W-1] || (pos_x == '0);
        neg_y_next = pos_y[MAG_W-1] || (pos_y == '0);
        abs_x      = neg_x_next ? MAG_W'(~pos_x + 1'b1) : pos_x;
        abs_y      = neg_y_next ? MAG_W'(~pos_y + 1'b1) : pos_y;
        mag_x_next = (abs_x <= MAG_W'(cfg.dead)) ? '0 : abs_x - MAG_W'(cfg.dead);
        mag_y_next = (abs_y <= MAG_W'(cfg.dead)) ? '0 : abs_y - MAG_W'(cfg.dead);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s0_neg_x_reg <= neg_x_next;
            s0_neg_y_reg <= neg_y_next;
            s0_mag_x_reg <= mag_x_next;
            s0_mag_y_reg <= mag_y_next;
        end
    end

    // Stage 1: pick the major axis, form the three products
    logic                              x_major;
    logic [MAG_W-1:0]                  major, minor;
    logic signed [MAG_W-1:0]           span;
    logic [aosc_pkg::PA_W-1:0]         pa_next;
    logic signed [aosc_pkg::PB_W-1:0]  pb_next;
    logic [aosc_pkg::WM_W-1:0]         wm_next;
    logic                              s1_neg_x_reg, s1_neg_y_reg;
    logic [MAG_W-1:0]                  s1_mag_x_reg, s1_mag_y_reg;
    logic [aosc_pkg::PA_W-1:0]         s1_pa_reg;
    logic signed [aosc_pkg::PB_W-1:0]  s1_pb_reg;
    logic [aosc_pkg::WM_W-1:0]         s1_wm_reg;

    always_comb begin
        x_major = (cfg.diag == '0) || (s0_mag_y_reg <= s0_mag_x_reg);
        major   = x_major ? s0_mag_x_reg : s0_mag_y_reg;
        minor   = x_major ? s0_mag_y_reg : s0_mag_x_reg;
        span    = $signed({1'b0, cfg.limit}) - $signed({1'b0, cfg.diag});
        pa_next = aosc_pkg::PA_W'(major) * aosc_pkg::PA_W'(cfg.diag);
        pb_next = aosc_pkg::PB_W'(span) * $signed(aosc_pkg::PB_W'(minor));
        wm_next = aosc_pkg::WM_W'(cfg.diag) * aosc_pkg::WM_W'(cfg.limit);
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s1_neg_x_reg <= s0_neg_x_reg;
            s1_neg_y_reg <= s0_neg_y_reg;
            s1_mag_x_reg <= s0_mag_x_reg;
            s1_mag_y_reg <= s0_mag_y_reg;
            s1_pa_reg    <= pa_next;
            s1_pb_reg    <= pb_next;
            s1_wm_reg    <= wm_next;
        end
    end

    // Stage 2: octagon distance, outside test, scaled numerators
    logic signed [aosc_pkg::SUM_W-1:0] oct_dist;
    logic                              scale_next;
    logic [aosc_pkg::NUM_W-1:0]        num_x_next, num_y_next;
    aosc_pkg::aosc_side_t              s2_side_reg;
    logic [aosc_pkg::DEN_W-1:0]        s2_den_reg;
    logic [aosc_pkg::NUM_W-1:0]        s2_num_x_reg, s2_num_y_reg;

    always_comb begin
        oct_dist   = $signed(aosc_pkg::SUM_W'(s1_pa_reg)) + aosc_pkg::SUM_W'(s1_pb_reg);
        scale_next = $signed(aosc_pkg::SUM_W'(s1_wm_reg)) < oct_dist;
        num_x_next = aosc_pkg::NUM_W'(s1_wm_reg) * aosc_pkg::NUM_W'(s1_mag_x_reg);
        num_y_next = aosc_pkg::NUM_W'(s1_wm_reg) * aosc_pkg::NUM_W'(s1_mag_y_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s2_side_reg.neg_x <= s1_neg_x_reg;
            s2_side_reg.neg_y <= s1_neg_y_reg;
            s2_side_reg.scale <= scale_next;
            s2_side_reg.mag_x <= s1_mag_x_reg;
            s2_side_reg.mag_y <= s1_mag_y_reg;
            s2_den_reg        <= oct_dist[aosc_pkg::DEN_W-1:0];
            s2_num_x_reg      <= num_x_next;
            s2_num_y_reg      <= num_y_next;
        end
    end

    // Divider stages: both axes share the divisor
    logic [aosc_pkg::DIV_STEPS-1:0] div_en;
    logic [aosc_pkg::QUO_W-1:0]     quo_x, quo_y;
    aosc_pkg::aosc_side_t           side_reg [aosc_pkg::DIV_STEPS];

    assign div_en = en[aosc_pkg::FRONT_STG +: aosc_pkg::DIV_STEPS];

    aosc_div u_div_x (
        .aclk (aclk),
        .en   (div_en),
        .num  (s2_num_x_reg),
        .den  (s2_den_reg),
        .quo  (quo_x)
    );

    aosc_div u_div_y (
        .aclk (aclk),
        .en   (div_en),
        .num  (s2_num_y_reg),
        .den  (s2_den_reg),
        .quo  (quo_y)
    );

    // Carry signs and unscaled magnitudes beside the divider
    always_ff @(posedge aclk) begin
        if (div_en[0]) begin
            side_reg[0] <= s2_side_reg;
        end
        for (int i = 1; i < aosc_pkg::DIV_STEPS; i++) begin
            if (div_en[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Output stage: choose scaled or plain magnitude, restore sign
    aosc_pkg::aosc_side_t side_last;
    logic [MAG_W-1:0]     res_x, res_y;
    logic [MAG_W-1:0]     out_x_next, out_y_next;
    logic [MAG_W-1:0]     out_x_reg, out_y_reg;

    always_comb begin
        side_last  = side_reg[aosc_pkg::DIV_STEPS-1];
        res_x      = side_last.scale ? quo_x : side_last.mag_x;
        res_y      = side_last.scale ? quo_y : side_last.mag_y;
        out_x_next = side_last.neg_x ? MAG_W'(~res_x + 1'b1) : res_x;
        out_y_next = side_last.neg_y ? MAG_W'(~res_y + 1'b1) : res_y;
    end

    always_ff @(posedge aclk) begin
        if (en[LAST]) begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
        end
    end

    assign out_x = out_x_reg;
    assign out_y = out_y_reg;

endmodule

// ===== rtl/analog_stick_octagon_clamp_top.sv =====
// Register stages: three front stages, nine divider steps, one output stage.
// Every stage, each divider step included, takes a new word.
// Throughput: one word per cycle without an output stall.
// A stall holds only the stages behind it; bubbles ahead of a stall still fill.
// Reset (aresetn low, synchronous) empties the pipeline and restores register defaults.
// Top level: register file, stage valid chain, trigger path, two stick paths.
// Depends on aosc_pkg and aosc_stick.
module analog_stick_octagon_clamp_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata, lowest bit up: left_x, left_y, right_x, right_y, trig_left, trig_right, pad
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [aosc_pkg::TDATA_W-1:0]    s_tdata,
    // m_tdata, lowest bit up: out_left_x, out_left_y, out_right_x, out_right_y,
    // out_trig_left, out_trig_right, pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [aosc_pkg::TDATA_W-1:0]    m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [aosc_pkg::ADDR_W-1:0]     cfg_addr,
    input  logic [aosc_pkg::CFG_W-1:0]      cfg_data
);

    localparam int DW   = aosc_pkg::DATA_W;
    localparam int CW   = aosc_pkg::CFG_W;
    localparam int LAST = aosc_pkg::NUM_STG - 1;

    // Register file
    logic [CW-1:0] trig_dead_reg, trig_limit_reg;
    logic [CW-1:0] left_dead_reg, left_limit_reg, left_diag_reg;
    logic [CW-1:0] right_dead_reg, right_limit_reg, right_diag_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_dead_reg   <= aosc_pkg::TRIG_DEAD_RST;
            trig_limit_reg  <= aosc_pkg::TRIG_LIMIT_RST;
            left_dead_reg   <= aosc_pkg::LEFT_DEAD_RST;
            left_limit_reg  <= aosc_pkg::LEFT_LIMIT_RST;
            left_diag_reg   <= aosc_pkg::LEFT_DIAG_RST;
            right_dead_reg  <= aosc_pkg::RIGHT_DEAD_RST;
            right_limit_reg <= aosc_pkg::RIGHT_LIMIT_RST;
            right_diag_reg  <= aosc_pkg::RIGHT_DIAG_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (aosc_pkg::aosc_reg_t'(cfg_addr))
                aosc_pkg::REG_TRIG_DEAD:   trig_dead_reg   <= cfg_data;
                aosc_pkg::REG_TRIG_LIMIT:  trig_limit_reg  <= cfg_data;
                aosc_pkg::REG_LEFT_DEAD:   left_dead_reg   <= cfg_data;
                aosc_pkg::REG_LEFT_LIMIT:  left_limit_reg  <= cfg_data;
                aosc_pkg::REG_LEFT_DIAG:   left_diag_reg   <= cfg_data;
                aosc_pkg::REG_RIGHT_DEAD:  right_dead_reg  <= cfg_data;
                aosc_pkg::REG_RIGHT_LIMIT: right_limit_reg <= cfg_data;
                aosc_pkg::REG_RIGHT_DIAG:  right_diag_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when empty or when its word moves on
    aosc_pkg::aosc_en_t en;
    aosc_pkg::aosc_en_t valid_reg, valid_next;

    always_comb begin
        en[LAST] = !valid_reg[LAST] || m_tready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        for (int k = 0; k <= LAST; k++) begin
            if (!en[k]) begin
                valid_next[k] = valid_reg[k];
            end else if (k == 0) begin
                valid_next[k] = s_tvalid;
            end else begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[LAST];

    // Unpack the input word
    logic [DW-1:0] in_left_x, in_left_y, in_right_x, in_right_y;
    logic [DW-1:0] in_trig_left, in_trig_right;

    assign in_left_x     = s_tdata[0*DW +: DW];
    assign in_left_y     = s_tdata[1*DW +: DW];
    assign in_right_x    = s_tdata[2*DW +: DW];
    assign in_right_y    = s_tdata[3*DW +: DW];
    assign in_trig_left  = s_tdata[4*DW +: DW];
    assign in_trig_right = s_tdata[5*DW +: DW];

    // Triggers: zero below dead, cap at limit, subtract dead
    logic signed [DW:0] t_dead, t_limit;
    logic signed [DW:0] tl_ext, tr_ext, tl_cap, tr_cap, tl_res, tr_res;
    logic [DW-1:0]      trig_l_next, trig_r_next;
    logic [DW-1:0]      trig_l_reg [aosc_pkg::NUM_STG];
    logic [DW-1:0]      trig_r_reg [aosc_pkg::NUM_STG];

    always_comb begin
        t_dead      = $signed({2'b00, trig_dead_reg});
        t_limit     = $signed({2'b00, trig_limit_reg});
        tl_ext      = $signed({in_trig_left[DW-1], in_trig_left});
        tr_ext      = $signed({in_trig_right[DW-1], in_trig_right});
        tl_cap      = (t_limit < tl_ext) ? t_limit : tl_ext;
        tr_cap      = (t_limit < tr_ext) ? t_limit : tr_ext;
        tl_res      = (t_dead > tl_ext) ? '0 : tl_cap - t_dead;
        tr_res      = (t_dead > tr_ext) ? '0 : tr_cap - t_dead;
        trig_l_next = tl_res[DW-1:0];
        trig_r_next = tr_res[DW-1:0];
    end

    // Delay trigger results to line up with the stick paths
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            trig_l_reg[0] <= trig_l_next;
            trig_r_reg[0] <= trig_r_next;
        end
        for (int k = 1; k <= LAST; k++) begin
            if (en[k]) begin
                trig_l_reg[k] <= trig_l_reg[k-1];
                trig_r_reg[k] <= trig_r_reg[k-1];
            end
        end
    end

    // Stick paths
    aosc_pkg::aosc_stick_cfg_t left_cfg, right_cfg;
    logic [DW-1:0] out_left_x, out_left_y, out_right_x, out_right_y;

    assign left_cfg  = '{dead: left_dead_reg, limit: left_limit_reg, diag: left_diag_reg};
    assign right_cfg = '{dead: right_dead_reg, limit: right_limit_reg, diag: right_diag_reg};

    aosc_stick u_left (
        .aclk  (aclk),
        .en    (en),
        .cfg   (left_cfg),
        .pos_x (in_left_x),
        .pos_y (in_left_y),
        .out_x (out_left_x),
        .out_y (out_left_y)
    );

    aosc_stick u_right (
        .aclk  (aclk),
        .en    (en),
        .cfg   (right_cfg),
        .pos_x (in_right_x),
        .pos_y (in_right_y),
        .out_x (out_right_x),
        .out_y (out_right_y)
    );

    // Pack the result word
    assign m_tdata = {
        (aosc_pkg::TDATA_W - aosc_pkg::NUM_FIELD * DW)'(0),
        trig_r_reg[LAST], trig_l_reg[LAST],
        out_right_y, out_right_x, out_left_y, out_left_x
    };

endmodule

// ===== rtl/aosc_chk.sv =====
// Port-level checks for the octagon clamp top level, attached by bind.
// Depends on aosc_pkg and analog_stick_octagon_clamp_top.
module aosc_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [aosc_pkg::TDATA_W-1:0]    m_tdata
);

    localparam int PAD_LO = aosc_pkg::NUM_FIELD * aosc_pkg::DATA_W;

    // A stalled result word stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // Input back-pressure only when the output side is stalled
    a_bp: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input held off without an output stall");

    // Padding bits of a result word stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[aosc_pkg::TDATA_W-1:PAD_LO] == '0)
        else $error("result padding not zero");

endmodule

bind analog_stick_octagon_clamp_top aosc_chk u_aosc_chk (.*);

// ===== tb/octagon_clamp_checker.sv =====
// Scoreboard for the octagon clamp block: watches the sample, result and register channels.
// Predicts each result word from the accepted sample and the current register copy.
// Depends on aosc_pkg for widths, register codes and reset values.
module octagon_clamp_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // s_tdata, lowest bit up: left_x, left_y, right_x, right_y, trig_left, trig_right, pad
    input  logic [aosc_pkg::TDATA_W-1:0]    s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, lowest bit up: out_left_x, out_left_y, out_right_x, out_right_y,
    // out_trig_left, out_trig_right, pad
    input  logic [aosc_pkg::TDATA_W-1:0]    m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [aosc_pkg::ADDR_W-1:0]     cfg_addr,
    input  logic [aosc_pkg::CFG_W-1:0]      cfg_data,
    output int                              fail_count,
    output int                              pending,
    output int                              results_seen
);
    import aosc_pkg::*;

    localparam int FIELDS_W = NUM_FIELD * DATA_W;

    logic [CFG_W-1:0]    region_regs [8];
    logic [FIELDS_W-1:0] clamped_q [$];
    int                  bad_count = 0;
    int                  result_count = 0;

    initial begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
    end

    function automatic string field_name(input int idx);
        case (idx)
            0:       return "out_left_x";
            1:       return "out_left_y";
            2:       return "out_right_x";
            3:       return "out_right_y";
            4:       return "out_trig_left";
            default: return "out_trig_right";
        endcase
    endfunction

    // Dead zone, then octagon rescale; zero counts as a negative position
    function automatic void clamp_stick(input int px, input int py, input int dead,
                                        input int lim, input int diag,
                                        output int ox, output int oy);
        bit neg_x;
        bit neg_y;
        int mx;
        int my;
        int oct_dist;
        neg_x = (px <= 0);
        neg_y = (py <= 0);
        mx = neg_x ? -px : px;
        my = neg_y ? -py : py;
        mx = (mx <= dead) ? 0 : mx - dead;
        my = (my <= dead) ? 0 : my - dead;
        if (diag * my <= diag * mx)
            oct_dist = diag * mx + (lim - diag) * my;
        else
            oct_dist = diag * my + (lim - diag) * mx;
        // Scale only when outside; a non-positive distance never scales
        if (diag * lim < oct_dist) begin
            mx = (diag * lim * mx) / oct_dist;
            my = (diag * lim * my) / oct_dist;
        end
        ox = neg_x ? -mx : mx;
        oy = neg_y ? -my : my;
    endfunction

    function automatic int condition_trigger(input int t);
        int dead;
        int lim;
        dead = region_regs[REG_TRIG_DEAD];
        lim  = region_regs[REG_TRIG_LIMIT];
        if (t < dead)
            return 0;
        if (t > lim)
            t = lim;
        return t - dead;
    endfunction

    function automatic logic [FIELDS_W-1:0] predict_clamped(input logic [TDATA_W-1:0] w);
        int                  pos [NUM_FIELD];
        int                  res [NUM_FIELD];
        logic [FIELDS_W-1:0] word;
        int                  i;
        for (i = 0; i < NUM_FIELD; i++)
            pos[i] = int'($signed(w[DATA_W*i +: DATA_W]));
        clamp_stick(pos[0], pos[1], region_regs[REG_LEFT_DEAD], region_regs[REG_LEFT_LIMIT],
                    region_regs[REG_LEFT_DIAG], res[0], res[1]);
        clamp_stick(pos[2], pos[3], region_regs[REG_RIGHT_DEAD],
                    region_regs[REG_RIGHT_LIMIT], region_regs[REG_RIGHT_DIAG],
                    res[2], res[3]);
        res[4] = condition_trigger(pos[4]);
        res[5] = condition_trigger(pos[5]);
        for (i = 0; i < NUM_FIELD; i++)
            word[DATA_W*i +: DATA_W] = res[i][DATA_W-1:0];
        return word;
    endfunction

    always @(posedge aclk) begin
        logic [FIELDS_W-1:0] want;
        int                  i;
        if (!aresetn) begin
            // Restore register defaults and drop anything in flight
            region_regs[REG_TRIG_DEAD]   = TRIG_DEAD_RST;
            region_regs[REG_TRIG_LIMIT]  = TRIG_LIMIT_RST;
            region_regs[REG_LEFT_DEAD]   = LEFT_DEAD_RST;
            region_regs[REG_LEFT_LIMIT]  = LEFT_LIMIT_RST;
            region_regs[REG_LEFT_DIAG]   = LEFT_DIAG_RST;
            region_regs[REG_RIGHT_DEAD]  = RIGHT_DEAD_RST;
            region_regs[REG_RIGHT_LIMIT] = RIGHT_LIMIT_RST;
            region_regs[REG_RIGHT_DIAG]  = RIGHT_DIAG_RST;
            clamped_q.delete();
        end else begin
            // Compare a result word against the oldest prediction
            if (m_tvalid && m_tready) begin
                result_count++;
                if (clamped_q.size() == 0) begin
                    $error("result word with no sample outstanding: %h", m_tdata);
                    bad_count++;
                end else begin
                    want = clamped_q.pop_front();
                    for (i = 0; i < NUM_FIELD; i++) begin
                        if (m_tdata[DATA_W*i +: DATA_W] !== want[DATA_W*i +: DATA_W]) begin
                            $error("%s: expected %0d, got %0d", field_name(i),
                                   $signed(want[DATA_W*i +: DATA_W]),
                                   $signed(m_tdata[DATA_W*i +: DATA_W]));
                            bad_count++;
                        end
                    end
                end
            end
            // Track register writes
            if (cfg_valid && cfg_ready)
                region_regs[cfg_addr] = cfg_data;
            // Predict each accepted sample word
            if (s_tvalid && s_tready)
                clamped_q.push_back(predict_clamped(s_tdata));
        end
        pending      <= clamped_q.size();
        fail_count   <= bad_count;
        results_seen <= result_count;
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the octagon clamp bench: clock, reset, sample and register stimulus, verdict.
// Instantiates the block and octagon_clamp_checker; depends on aosc_pkg.
module testbench;
    import aosc_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int LATENCY      = 13;
    localparam int LONG_HOLD    = 100;
    localparam int FIELDS_W     = NUM_FIELD * DATA_W;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [ADDR_W-1:0]   cfg_addr  = REG_TRIG_DEAD;
    logic [CFG_W-1:0]    cfg_data  = '0;

    int fail_count;
    int pending;
    int results_seen;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    logic hold_req    = 1'b0;
    logic hold_taken  = 1'b0;
    int n_sent        = 0;
    int n_settings    = 1;

    analog_stick_octagon_clamp_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    octagon_clamp_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Result side: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            m_tready   <= 1'b0;
            hold_left  <= LONG_HOLD;
            hold_taken <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // End the run when no word moves on any channel for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [FIELDS_W-1:0] pack_sample(input int lx, input int ly,
                                                        input int rx, input int ry,
                                                        input int tl, input int tr);
        logic [FIELDS_W-1:0] w;
        w = {tr[DATA_W-1:0], tl[DATA_W-1:0], ry[DATA_W-1:0],
             rx[DATA_W-1:0], ly[DATA_W-1:0], lx[DATA_W-1:0]};
        return w;
    endfunction

    // Mostly raw bits, some values around the dead zones, some range extremes
    function automatic logic [DATA_W-1:0] pick_position();
        int sel;
        int v;
        sel = $urandom_range(9);
        if (sel < 6) begin
            v = $urandom_range(511);
        end else if (sel < 8) begin
            v = int'($urandom_range(80)) - 40;
        end else begin
            case ($urandom_range(3))
                0:       v = -256;
                1:       v = -255;
                2:       v = 255;
                default: v = 0;
            endcase
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic [FIELDS_W-1:0] random_sample();
        logic [FIELDS_W-1:0] w;
        int                  i;
        for (i = 0; i < NUM_FIELD; i++)
            w[DATA_W*i +: DATA_W] = pick_position();
        return w;
    endfunction

    // Offer one sample word after a random gap; return at its accepting edge
    task automatic send_sample(input logic [FIELDS_W-1:0] fields);
        if (n_sent < 150) begin
            send_idle_pct = 31;
            recv_idle_pct <= 79;
        end else if (n_sent < 300) begin
            send_idle_pct = 79;
            recv_idle_pct <= 31;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W-FIELDS_W){1'b0}}, fields};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        n_sent++;
    endtask

    // Hold the sample side until every predicted result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input aosc_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] t_dead, input logic [CFG_W-1:0] t_lim,
                                 input logic [CFG_W-1:0] l_dead, input logic [CFG_W-1:0] l_lim,
                                 input logic [CFG_W-1:0] l_diag, input logic [CFG_W-1:0] r_dead,
                                 input logic [CFG_W-1:0] r_lim, input logic [CFG_W-1:0] r_diag);
        write_reg(REG_TRIG_DEAD, t_dead);
        write_reg(REG_TRIG_LIMIT, t_lim);
        write_reg(REG_LEFT_DEAD, l_dead);
        write_reg(REG_LEFT_LIMIT, l_lim);
        write_reg(REG_LEFT_DIAG, l_diag);
        write_reg(REG_RIGHT_DEAD, r_dead);
        write_reg(REG_RIGHT_LIMIT, r_lim);
        write_reg(REG_RIGHT_DIAG, r_diag);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    initial begin : stimulus
        int k;
        int p;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed samples under the reset settings
        send_sample(pack_sample(0, 0, 0, 0, 0, 0));
        send_sample(pack_sample(-256, -256, -256, -256, -256, -256));
        send_sample(pack_sample(255, 255, 255, 255, 255, 255));
        send_sample(pack_sample(-255, -255, -255, -255, -255, -255));
        // inside the dead zones; triggers just below and at the dead value
        send_sample(pack_sample(10, -10, 15, -15, 29, 30));
        // one past the dead zone; trigger at its cap
        send_sample(pack_sample(16, -16, -16, 16, 31, 180));
        // on-axis extremes; trigger above its cap
        send_sample(pack_sample(255, 0, 0, 255, 181, 255));
        // zero axis counts as negative; negative triggers
        send_sample(pack_sample(0, 255, -255, 0, -1, -256));
        // full diagonals, well outside the octagon
        send_sample(pack_sample(255, 255, -255, -255, 100, -255));
        // inside the octagon, left untouched
        send_sample(pack_sample(40, 20, -30, 25, 200, 179));
        // both octagon branches: x above y, then y above x
        send_sample(pack_sample(100, 60, -200, 90, 45, 150));
        send_sample(pack_sample(60, 100, 90, -200, 120, 60));
        send_sample(pack_sample(87, 87, 74, -74, 1, 254));
        send_sample(pack_sample(-256, 1, 1, -256, 0, 179));

        // Random samples; one long result-side hold-off partway through
        for (k = 0; k < 76; k++) begin
            if (k == 30)
                hold_req <= 1'b1;
            send_sample(random_sample());
        end

        // Further settings: extremes, zero diagonal, limit under diagonal, random
        for (p = 1; p <= 6; p++) begin
            settle();
            case (p)
                1: load_settings(8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0);
                2: load_settings(8'd0, 8'd255, 8'd0, 8'd10, 8'd200, 8'd0, 8'd255, 8'd0);
                4: load_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                5: load_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                                 8'd255);
                default: load_settings(CFG_W'($urandom_range(255)),
                                       CFG_W'($urandom_range(255)),
                                       CFG_W'($urandom_range(60)),
                                       CFG_W'($urandom_range(255)),
                                       CFG_W'($urandom_range(255)),
                                       CFG_W'($urandom_range(60)),
                                       CFG_W'($urandom_range(255)),
                                       CFG_W'($urandom_range(255)));
            endcase
            repeat (60) send_sample(random_sample());
        end

        // Drain, then allow the pipeline to show any stray word
        settle();
        repeat (LATENCY + 8) @(posedge aclk);

        $display("Covered %0d samples over %0d register settings, including extremes,", n_sent,
                 n_settings);
        $display("zero diagonal and limit below diagonal; %0d results compared, %0d mismatches",
                 results_seen, fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
